// File: hw/rtl/lwr_pkg.sv
// shared types and constants for the longest window within range block
// no dependencies; imported by every other file of the block except lwr_ram

package lwr_pkg;

    // sequence and value sizing
    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 11;
    localparam int POS_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int ENTRY_W    = POS_W + VALUE_BITS;

    // configuration port
    localparam int CFG_W      = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_SPREAD_LIMIT = '0;

    // one deque entry
    typedef struct packed {
        logic [POS_W-1:0]      pos;
        logic [VALUE_BITS-1:0] val;
    } entry_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_PUSH,
        ST_TRIM,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
        logic push;
        logic trim;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic any_pop;
        logic exceed;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/lwr_if.sv
// valid/ready stream interfaces for the sample input and the result output
// depends on lwr_pkg for field widths

interface lwr_in_if import lwr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface lwr_out_if import lwr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] window_length;
    logic [LEN_W-1:0] best_length;
    logic             overflow;

    modport source (output valid, output window_length, output best_length,
                    output overflow, input ready);
    modport sink (input valid, input window_length, input best_length,
                  input overflow, output ready);
endinterface

// File: hw/rtl/lwr_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module lwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lwr_ctrl.sv
// sequencer for one item: pop back entries, push, trim fronts, deliver result
// depends on lwr_pkg for state, command and status types

module lwr_ctrl import lwr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.full ? ST_DONE : ST_POP;
                end
            end
            ST_POP:
            begin
                if (!status.any_pop)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                if (!status.exceed)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_POP:
            begin
                cmd.pop = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
            end
            ST_TRIM:
            begin
                cmd.trim = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/lwr_dp.sv
// datapath: min and max deques in ram, head/tail pointers, window bounds, result
// depends on lwr_pkg and lwr_ram

module lwr_dp import lwr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [CFG_W-1:0]    spread_limit,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                start_req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEN_W-1:0]    window_length,
    output logic [LEN_W-1:0]    best_length,
    output logic                overflow
);

    // control state
    logic [IDX_W-1:0] min_head_reg, min_head_next;
    logic [IDX_W-1:0] max_head_reg, max_head_next;
    logic [POS_W-1:0] min_tail_reg, min_tail_next;
    logic [POS_W-1:0] max_tail_reg, max_tail_next;
    logic [POS_W-1:0] min_drop_reg, min_drop_next;
    logic [POS_W-1:0] max_drop_reg, max_drop_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] best_reg, best_next;
    logic             ovf_reg, ovf_next;
    logic             min_byp_reg, min_byp_next;
    logic             max_byp_reg, max_byp_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [VALUE_BITS-1:0] val_reg;
    logic [LEN_W-1:0]      win_out_reg;
    logic [LEN_W-1:0]      best_out_reg;
    logic                  ovf_out_reg;

    // memory ports
    logic [ENTRY_W-1:0] min_rdata, max_rdata;
    logic [IDX_W-1:0]   min_raddr, max_raddr;
    entry_t             new_entry;
    entry_t             min_back, max_back;
    entry_t             min_front, max_front;

    // comparisons
    logic                  min_nonempty, max_nonempty;
    logic                  pop_min, pop_max;
    logic                  exceed, drop_max;
    logic [VALUE_BITS-1:0] spread;
    logic [POS_W-1:0]      left;
    logic [POS_W-1:0]      len;
    logic                  full;

    assign new_entry = '{pos: pos_reg, val: val_reg};
    assign min_back  = entry_t'(min_rdata);
    assign max_back  = entry_t'(max_rdata);

    // newly pushed entry bypasses the ram when it is also the front
    assign min_front = min_byp_reg ? new_entry : min_back;
    assign max_front = max_byp_reg ? new_entry : max_back;

    // back pop tests
    assign min_nonempty = min_tail_reg > {1'b0, min_head_reg};
    assign max_nonempty = max_tail_reg > {1'b0, max_head_reg};
    assign pop_min      = min_nonempty && (min_back.val > val_reg);
    assign pop_max      = max_nonempty && (max_back.val < val_reg);

    // front trim test
    assign spread   = max_front.val - min_front.val;
    assign exceed   = (max_front.val < min_front.val) || (spread > spread_limit);
    assign drop_max = max_front.pos < min_front.pos;

    // window length from the later of the two drop marks
    assign left = (min_drop_reg > max_drop_reg) ? min_drop_reg : max_drop_reg;
    assign len  = pos_reg - left;

    assign full = !start_req && (pos_reg == POS_W'(MAX_LEN));

    assign status.full     = full;
    assign status.any_pop  = pop_min || pop_max;
    assign status.exceed   = exceed;
    assign status.out_free = !out_valid_reg || out_ready;

    // read addresses point at the entry examined in the next cycle
    always_comb
    begin
        min_raddr = min_head_reg;
        max_raddr = max_head_reg;
        if (cmd.load)
        begin
            min_raddr = IDX_W'(min_tail_reg - POS_W'(1));
            max_raddr = IDX_W'(max_tail_reg - POS_W'(1));
        end
        else if (cmd.pop)
        begin
            min_raddr = IDX_W'(min_tail_reg - (pop_min ? POS_W'(2) : POS_W'(1)));
            max_raddr = IDX_W'(max_tail_reg - (pop_max ? POS_W'(2) : POS_W'(1)));
        end
        else if (cmd.trim && exceed)
        begin
            min_raddr = drop_max ? min_head_reg : min_head_reg + IDX_W'(1);
            max_raddr = drop_max ? max_head_reg + IDX_W'(1) : max_head_reg;
        end
    end

    // deque storage
    lwr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_min_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (min_tail_reg[IDX_W-1:0]),
        .wdata (new_entry),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    lwr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_max_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (max_tail_reg[IDX_W-1:0]),
        .wdata (new_entry),
        .raddr (max_raddr),
        .rdata (max_rdata)
    );

    // next values of control state
    always_comb
    begin
        min_head_next  = min_head_reg;
        max_head_next  = max_head_reg;
        min_tail_next  = min_tail_reg;
        max_tail_next  = max_tail_reg;
        min_drop_next  = min_drop_reg;
        max_drop_next  = max_drop_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        min_byp_next   = 1'b0;
        max_byp_next   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            // start of a new sequence clears the pointers, drop marks and best length first
            if (start_req)
            begin
                min_head_next = '0;
                max_head_next = '0;
                min_tail_next = '0;
                max_tail_next = '0;
                min_drop_next = '0;
                max_drop_next = '0;
                best_next     = '0;
                pos_next      = POS_W'(1);
            end
            else if (!full)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            ovf_next = full;
        end

        if (cmd.pop)
        begin
            if (pop_min)
            begin
                min_tail_next = min_tail_reg - POS_W'(1);
            end
            if (pop_max)
            begin
                max_tail_next = max_tail_reg - POS_W'(1);
            end
        end

        if (cmd.push)
        begin
            min_tail_next = min_tail_reg + POS_W'(1);
            max_tail_next = max_tail_reg + POS_W'(1);
            min_byp_next  = min_tail_reg == {1'b0, min_head_reg};
            max_byp_next  = max_tail_reg == {1'b0, max_head_reg};
        end

        // drop the older front while the spread is too wide
        if (cmd.trim && exceed)
        begin
            if (drop_max)
            begin
                max_drop_next = max_front.pos;
                max_head_next = max_head_reg + IDX_W'(1);
            end
            else
            begin
                min_drop_next = min_front.pos;
                min_head_next = min_head_reg + IDX_W'(1);
            end
        end

        if (cmd.finish)
        begin
            if (!ovf_reg && (len > best_reg))
            begin
                best_next = len;
            end
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_head_reg  <= '0;
            max_head_reg  <= '0;
            min_tail_reg  <= '0;
            max_tail_reg  <= '0;
            min_drop_reg  <= '0;
            max_drop_reg  <= '0;
            pos_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            min_byp_reg   <= 1'b0;
            max_byp_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_head_reg  <= min_head_next;
            max_head_reg  <= max_head_next;
            min_tail_reg  <= min_tail_next;
            max_tail_reg  <= max_tail_next;
            min_drop_reg  <= min_drop_next;
            max_drop_reg  <= max_drop_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            min_byp_reg   <= min_byp_next;
            max_byp_reg   <= max_byp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= sample[VALUE_BITS-1:0];
        end
        if (cmd.finish)
        begin
            win_out_reg  <= ovf_reg ? '0 : LEN_W'(len);
            best_out_reg <= LEN_W'(best_next);
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_length = win_out_reg;
    assign best_length   = best_out_reg;
    assign overflow      = ovf_out_reg;

endmodule

// File: hw/rtl/longest_window_within_range.sv
// Longest window within range: for every sample, the length of the longest window ending
// there whose maximum minus minimum is at most spread_limit, and the best length so far.
// An item steps through idle, pop, push, trim and done: back entries are removed from the
// min and max deques in parallel, then front entries are trimmed; this is set by the single
// read port of each deque memory, which is stepped one entry per cycle. Over a sequence each
// entry is pushed and removed at most once. An item arriving after MAX_LEN items of a
// sequence goes from idle straight to done and returns overflow. No clearing pass follows
// reset. A finished result waits in the output register while the next item is taken in;
// spread_limit is written over the APB port at byte address 0.
// depends on lwr_pkg, lwr_if, lwr_ctrl, lwr_dp

module longest_window_within_range import lwr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    lwr_in_if.sink                samples,
    lwr_out_if.source             results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]      pwdata,
    output logic [CFG_W-1:0]      prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] spread_limit_reg;
    logic             cfg_sel;
    cmd_t             cmd;
    status_t          status;

    // configuration register
    assign pready  = 1'b1;
    assign cfg_sel = paddr[APB_ADDR_W-1:2] == REG_SPREAD_LIMIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_limit_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            spread_limit_reg <= pwdata;
        end
    end

    assign prdata = cfg_sel ? spread_limit_reg : '0;

    // sequencer
    lwr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // deques and result
    lwr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .spread_limit  (spread_limit_reg),
        .sample        (samples.sample),
        .start_req     (samples.start_req),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .window_length (results.window_length),
        .best_length   (results.best_length),
        .overflow      (results.overflow)
    );

    // an ignored item reports an empty window
    a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.overflow |-> results.window_length == '0)
        else $error("overflow result with nonzero window length");

    // a real window holds at least the current item and never beats the best
    a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.overflow |->
            (results.window_length != '0) &&
            (results.window_length <= results.best_length))
        else $error("window length outside of its bounds");

    // one item at a time: no second transaction right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("input ready right after an accepted transaction");

    // best length never passes the sequence capacity
    a_best_cap: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.best_length <= LEN_W'(MAX_LEN))
        else $error("best length beyond sequence capacity");

endmodule
